[sv/pixel_color_effect_core_macros.svh]
// Assertion macros shared by the pixel color effect RTL.
`ifndef PIXEL_COLOR_EFFECT_CORE_MACROS_SVH
`define PIXEL_COLOR_EFFECT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, held off while reset is asserted (active low).
`define PCE_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pce: assertion failed");
// Checked property that also holds across reset.
`define PCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pce: assertion failed");
`else
`define PCE_ASSERT_RST(label, clk, rst_n, prop)
`define PCE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[sv/pce_pkg.sv]
`default_nettype none

package pce_pkg;

    localparam int MODE_W = 4;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 32;
    localparam int SUM_W  = 10;   // r+g+b <= 765
    localparam int NUM_W  = 14;   // largest numerator 35*255 = 8925
    localparam int RCP_W  = 16;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int QUO_W  = 10;   // largest quotient 13*255/10 = 331
    localparam int Q7_W   = 7;    // 765/7 = 109
    localparam int SH_W   = 5;

    // Effect codes
    localparam logic [MODE_W-1:0] MODE_NORMAL   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PRESSED  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_ROLLOVER = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MONO     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_PINK     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_YELLOW   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DARK     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CYAN     = 4'd8;

    // Reciprocals: floor(x/d) = (x*M) >> S, exact over each numerator's range
    localparam logic [RCP_W-1:0] RCP_DIV10  = 16'd52429;  // S=19
    localparam logic [RCP_W-1:0] RCP_DIV3   = 16'd43691;  // S=17
    localparam logic [RCP_W-1:0] RCP_DIV153 = 16'd6854;   // S=20
    localparam logic [RCP_W-1:0] RCP_DIV51  = 16'd20561;  // S=20
    localparam logic [RCP_W-1:0] RCP_DIV7   = 16'd9363;   // S=16

    localparam logic [SH_W-1:0] SH_DIV10  = 5'd19;
    localparam logic [SH_W-1:0] SH_DIV3   = 5'd17;
    localparam logic [SH_W-1:0] SH_DIV153 = 5'd20;
    localparam logic [SH_W-1:0] SH_DIV51  = 5'd20;
    localparam int              SH_DIV7   = 16;

    // Per-stage load enables from the top-level flow control
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

[sv/pce_datapath.sv]
`default_nettype none

module pce_datapath (
    input  wire logic                          i_clk,
    input  wire pce_pkg::t_pipe_ctrl           i_ctrl,
    input  wire logic [pce_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [pce_pkg::PIX_W-1:0]     i_pixel,
    output logic      [pce_pkg::PIX_W-1:0]     o_pixel
);

    localparam int NL = 3;   // lane 2 red, 1 green, 0 blue

    // Reciprocal for a lane under a given effect
    function automatic logic [pce_pkg::RCP_W-1:0] lane_rcp(
        input logic [pce_pkg::MODE_W-1:0] mode,
        input logic [1:0]                 lane
    );
        logic [pce_pkg::RCP_W-1:0] m;
        begin
            case (mode)
                pce_pkg::MODE_ERROR: m = (lane == 2'd2) ? pce_pkg::RCP_DIV3
                                                        : pce_pkg::RCP_DIV153;
                pce_pkg::MODE_PINK:  m = pce_pkg::RCP_DIV51;
                default:             m = pce_pkg::RCP_DIV10;
            endcase
            return m;
        end
    endfunction

    function automatic logic [pce_pkg::SH_W-1:0] lane_shift(
        input logic [pce_pkg::MODE_W-1:0] mode,
        input logic [1:0]                 lane
    );
        logic [pce_pkg::SH_W-1:0] sh;
        begin
            case (mode)
                pce_pkg::MODE_ERROR: sh = (lane == 2'd2) ? pce_pkg::SH_DIV3
                                                         : pce_pkg::SH_DIV153;
                pce_pkg::MODE_PINK:  sh = pce_pkg::SH_DIV51;
                default:             sh = pce_pkg::SH_DIV10;
            endcase
            return sh;
        end
    endfunction

    // ---------------- stage 1: numerators ----------------
    logic [NL-1:0][pce_pkg::CH_W-1:0]  chan;
    logic [pce_pkg::SUM_W-1:0]         sum;
    logic [pce_pkg::NUM_W-1:0]         mono;
    logic [NL-1:0][pce_pkg::NUM_W-1:0] n_x1;

    logic [pce_pkg::MODE_W-1:0]         r_mode1;
    logic [pce_pkg::PIX_W-1:0]          r_pix1;
    logic [pce_pkg::SUM_W-1:0]          r_sum1;
    logic [NL-1:0][pce_pkg::NUM_W-1:0]  r_x1;

    assign chan = i_pixel[NL*pce_pkg::CH_W-1:0];
    assign sum  = pce_pkg::SUM_W'(chan[2]) + pce_pkg::SUM_W'(chan[1])
                + pce_pkg::SUM_W'(chan[0]);
    assign mono = pce_pkg::NUM_W'(chan[2]) * pce_pkg::NUM_W'(4)
                + pce_pkg::NUM_W'(chan[1]) * pce_pkg::NUM_W'(7)
                + pce_pkg::NUM_W'(chan[0]) * pce_pkg::NUM_W'(2);

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            case (i_mode)
                pce_pkg::MODE_PRESSED:
                    n_x1[i] = pce_pkg::NUM_W'(chan[i]) * pce_pkg::NUM_W'(7);
                pce_pkg::MODE_ROLLOVER:
                    n_x1[i] = pce_pkg::NUM_W'(chan[i]) * pce_pkg::NUM_W'(13);
                pce_pkg::MODE_ERROR:
                    n_x1[i] = (i == 2) ? pce_pkg::NUM_W'(sum)
                                       : pce_pkg::NUM_W'({sum, 3'b000});
                pce_pkg::MODE_MONO:
                    n_x1[i] = mono;
                pce_pkg::MODE_PINK:
                    n_x1[i] = pce_pkg::NUM_W'(chan[i]) * pce_pkg::NUM_W'(35);
                pce_pkg::MODE_DARK:
                    n_x1[i] = pce_pkg::NUM_W'(chan[i]) * pce_pkg::NUM_W'(3);
                default:
                    n_x1[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_mode1 <= i_mode;
            r_pix1  <= i_pixel;
            r_sum1  <= sum;
            r_x1    <= n_x1;
        end
    end

    // ---------------- stage 2: reciprocal multiply ----------------
    logic [pce_pkg::MODE_W-1:0]         r_mode2;
    logic [pce_pkg::PIX_W-1:0]          r_pix2;
    logic [NL-1:0][pce_pkg::PROD_W-1:0] r_p2;
    logic [pce_pkg::Q7_W-1:0]           r_q7_2;
    logic [NL-1:0][pce_pkg::PROD_W-1:0] n_p2;
    logic [pce_pkg::SUM_W+pce_pkg::RCP_W-1:0] p7;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            n_p2[i] = pce_pkg::PROD_W'(r_x1[i])
                    * pce_pkg::PROD_W'(lane_rcp(r_mode1, 2'(i)));
        end
    end

    assign p7 = (pce_pkg::SUM_W+pce_pkg::RCP_W)'(r_sum1)
              * (pce_pkg::SUM_W+pce_pkg::RCP_W)'(pce_pkg::RCP_DIV7);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_mode2 <= r_mode1;
            r_pix2  <= r_pix1;
            r_p2    <= n_p2;
            r_q7_2  <= pce_pkg::Q7_W'(p7 >> pce_pkg::SH_DIV7);
        end
    end

    // ---------------- stage 3: shift, clamp, select ----------------
    logic [NL-1:0][pce_pkg::CH_W-1:0]  raw2;
    logic [NL-1:0][pce_pkg::QUO_W-1:0] quo;
    logic [NL-1:0][pce_pkg::CH_W-1:0]  sat;
    logic [NL-1:0][pce_pkg::CH_W-1:0]  n_ch3;
    logic [pce_pkg::PIX_W-1:0]         r_out;

    assign raw2 = r_pix2[NL*pce_pkg::CH_W-1:0];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            quo[i] = pce_pkg::QUO_W'(r_p2[i] >> lane_shift(r_mode2, 2'(i)));
            sat[i] = (quo[i] > pce_pkg::QUO_W'(255)) ? 8'hFF
                                                     : pce_pkg::CH_W'(quo[i]);
            case (r_mode2)
                pce_pkg::MODE_PRESSED,
                pce_pkg::MODE_ROLLOVER,
                pce_pkg::MODE_ERROR,
                pce_pkg::MODE_MONO:
                    n_ch3[i] = sat[i];
                pce_pkg::MODE_PINK:
                    n_ch3[i] = (i == 2) ? raw2[i] : sat[i];
                pce_pkg::MODE_YELLOW:
                    n_ch3[i] = (i == 0) ? '0 : raw2[i];
                pce_pkg::MODE_DARK:
                    n_ch3[i] = pce_pkg::CH_W'(quo[i]) + pce_pkg::CH_W'(r_q7_2);
                pce_pkg::MODE_CYAN:
                    n_ch3[i] = (i == 2) ? '0 : raw2[i];
                default:
                    n_ch3[i] = raw2[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_out <= {r_pix2[pce_pkg::PIX_W-1:NL*pce_pkg::CH_W], n_ch3};
        end
    end

    assign o_pixel = r_out;

endmodule

`default_nettype wire

[sv/pixel_color_effect_core.sv]
// Throughput: one pixel per clock while the output is not stalled; three
// registered stages (numerator build, reciprocal multiply, shift/clamp/select)
// with a valid bit each.
// i_stall reaches o_stall through the stage valid bits, so bubbles collapse.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the effect
// mode to normal.
`default_nettype none
`include "pixel_color_effect_core_macros.svh"

module pixel_color_effect_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [pce_pkg::MODE_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [pce_pkg::PIX_W-1:0]    i_pixel_in,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [pce_pkg::PIX_W-1:0]    o_pixel_out
);

    logic [pce_pkg::MODE_W-1:0] r_mode;
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic rdy1, rdy2, rdy3;
    pce_pkg::t_pipe_ctrl ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pce_pkg::MODE_NORMAL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or the stage after it moves on
    assign rdy3 = !r_v3 || !i_stall;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign ctrl.en1 = rdy1;
    assign ctrl.en2 = rdy2;
    assign ctrl.en3 = rdy3;

    assign n_v1 = rdy1 ? i_valid : r_v1;
    assign n_v2 = rdy2 ? r_v1    : r_v2;
    assign n_v3 = rdy3 ? r_v2    : r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    pce_datapath u_datapath (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_mode  (r_mode),
        .i_pixel (i_pixel_in),
        .o_pixel (o_pixel_out)
    );

    assign o_stall = !rdy1;
    assign o_valid = r_v3;

    // Back-pressure reaches the input only when every stage holds a word
    `PCE_ASSERT_RST(a_stall_full, i_clk, i_rst_n, o_stall |-> (r_v1 && r_v2 && r_v3))
    // An accepted word lands in the first stage
    `PCE_ASSERT_RST(a_accept_load, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_v1)
    // Reset leaves the pipeline empty and ready
    `PCE_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (!o_valid && !o_stall))

endmodule

`default_nettype wire
